[rtl/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, sizes and helpers for the signature correlation classifier.
// ----------------------------------------------------------------------------
package scc_pkg;

    // sizing of the classifier
    localparam int NUM_CLASSES = 4;
    localparam int VEC_LEN     = 256;
    localparam int ADDR_W      = $clog2(VEC_LEN);
    localparam int CLS_IDX_W   = $clog2(NUM_CLASSES);
    localparam int LEVELS      = $clog2(NUM_CLASSES);
    localparam int LEAVES      = 1 << LEVELS;

    // fixed field widths
    localparam int CLASS_W = 2;
    localparam int ELEM_W  = 8;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int TERM_W  = PROD_W + 1;
    localparam int ACC_W   = 48;
    localparam int HALF_W  = ACC_W / 2;
    localparam int MAG_W   = 2 * ACC_W;

    // result queue sizing, deeper than the pipeline latency
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

    // request types
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_FEATURE = 1'b1;

    // accumulator limits
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
    } t_cplx16;

    typedef t_cplx16 [NUM_CLASSES-1:0] t_sig_row;

    typedef struct packed {
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
    } t_acc_pair;

    // finished correlation set handed to the selector
    typedef struct packed {
        logic                                valid;
        t_acc_pair [NUM_CLASSES-1:0]         acc;
    } t_corr_req;

    // winner coming back from the selector
    typedef struct packed {
        logic                 valid;
        logic [CLS_IDX_W-1:0] idx;
    } t_best_rsp;

    // saturating accumulate of one product term
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [TERM_W-1:0] term
    );
        logic signed [ACC_W:0] sum;
        sum = (ACC_W+1)'(acc) + (ACC_W+1)'(term);
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            return sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return sum[ACC_W-1:0];
    endfunction

endpackage

[rtl/scc_best_select.sv]
// ----------------------------------------------------------------------------
// scc_best_select
// Squared magnitude of every class correlation and a registered max tree;
// ties go to the lower class index.
// ----------------------------------------------------------------------------
module scc_best_select (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  scc_pkg::t_corr_req   i_req,
    output scc_pkg::t_best_rsp   o_rsp
);

    localparam int NV = 2 * scc_pkg::NUM_CLASSES;

    typedef struct packed {
        logic [scc_pkg::MAG_W-1:0]     mag;
        logic [scc_pkg::CLS_IDX_W-1:0] idx;
    } t_node;

    logic                               r_v_abs;
    logic                               r_v_pp;
    logic                               r_v_sq;
    logic [scc_pkg::ACC_W-1:0]          r_abs [NV];
    logic [scc_pkg::ACC_W-1:0]          r_hh  [NV];
    logic [scc_pkg::ACC_W-1:0]          r_hl  [NV];
    logic [scc_pkg::ACC_W-1:0]          r_ll  [NV];
    logic [scc_pkg::MAG_W-1:0]          r_sq  [NV];
    logic                               r_lvl_valid [scc_pkg::LEVELS+1];
    t_node                              r_node [scc_pkg::LEVELS+1][scc_pkg::LEAVES];

    // valid tracking through the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_abs <= 1'b0;
            r_v_pp  <= 1'b0;
            r_v_sq  <= 1'b0;
            for (int l = 0; l <= scc_pkg::LEVELS; l++) begin
                r_lvl_valid[l] <= 1'b0;
            end
        end else begin
            r_v_abs        <= i_req.valid;
            r_v_pp         <= r_v_abs;
            r_v_sq         <= r_v_pp;
            r_lvl_valid[0] <= r_v_sq;
            for (int l = 1; l <= scc_pkg::LEVELS; l++) begin
                r_lvl_valid[l] <= r_lvl_valid[l-1];
            end
        end
    end

    // absolute values, split halves, partial products and squares
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < scc_pkg::NUM_CLASSES; c++) begin
            r_abs[2*c]   <= i_req.acc[c].re[scc_pkg::ACC_W-1] ?
                            (~i_req.acc[c].re + scc_pkg::ACC_W'(1)) : i_req.acc[c].re;
            r_abs[2*c+1] <= i_req.acc[c].im[scc_pkg::ACC_W-1] ?
                            (~i_req.acc[c].im + scc_pkg::ACC_W'(1)) : i_req.acc[c].im;
        end
        for (int k = 0; k < NV; k++) begin
            r_hh[k] <= scc_pkg::ACC_W'(r_abs[k][scc_pkg::ACC_W-1:scc_pkg::HALF_W])
                     * scc_pkg::ACC_W'(r_abs[k][scc_pkg::ACC_W-1:scc_pkg::HALF_W]);
            r_hl[k] <= scc_pkg::ACC_W'(r_abs[k][scc_pkg::ACC_W-1:scc_pkg::HALF_W])
                     * scc_pkg::ACC_W'(r_abs[k][scc_pkg::HALF_W-1:0]);
            r_ll[k] <= scc_pkg::ACC_W'(r_abs[k][scc_pkg::HALF_W-1:0])
                     * scc_pkg::ACC_W'(r_abs[k][scc_pkg::HALF_W-1:0]);
            // high and low squares do not overlap, the cross term lands on top
            r_sq[k] <= {r_hh[k], r_ll[k]}
                     + (scc_pkg::MAG_W'(r_hl[k]) << (scc_pkg::HALF_W + 1));
        end
    end

    // leaves of the max tree, padded leaves never win
    for (genvar n = 0; n < scc_pkg::LEAVES; n++) begin : g_leaf
        if (n < scc_pkg::NUM_CLASSES) begin : g_real
            always_ff @(posedge i_clk) begin
                r_node[0][n].mag <= r_sq[2*n] + r_sq[2*n+1];
                r_node[0][n].idx <= scc_pkg::CLS_IDX_W'(n);
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                r_node[0][n] <= '0;
            end
        end
    end

    // compare levels, right child wins only when strictly larger
    for (genvar l = 1; l <= scc_pkg::LEVELS; l++) begin : g_lvl
        for (genvar n = 0; n < (scc_pkg::LEAVES >> l); n++) begin : g_cmp
            always_ff @(posedge i_clk) begin
                if (r_node[l-1][2*n+1].mag > r_node[l-1][2*n].mag) begin
                    r_node[l][n] <= r_node[l-1][2*n+1];
                end else begin
                    r_node[l][n] <= r_node[l-1][2*n];
                end
            end
        end
    end

    assign o_rsp.valid = r_lvl_valid[scc_pkg::LEVELS];
    assign o_rsp.idx   = r_node[scc_pkg::LEVELS][0].idx;

endmodule

[rtl/signature_correlation_classifier_unit.sv]
// ----------------------------------------------------------------------------
// signature_correlation_classifier_unit
// Streaming nearest-template classifier over complex vectors with per-class
// correlation accumulators and a signature memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one request per unstalled cycle.
//   A load request writes one signature word for one class at one element.
//   A feature request reads the signature row at its element and adds
//   conj(signature) * feature into every class accumulator in parallel.
//   A feature request marked last produces one result on the output channel
//   (o_out_valid / i_out_stall) and clears the accumulators.
//   Throughput: one request per clock while o_in_stall is low, set by the
//   single-port signature memory read and the registered accumulate loop.
//   A result passes the capture, product and term stages, the accumulator
//   hand-off, the selector's max tree and the result queue before o_out_valid.
//   Results wait in a 16-entry queue; o_in_stall rises only when 16 results
//   are outstanding, so a stalled receiver backs up into the input channel.
//   Reset clears the accumulators, pipeline valids and the result queue;
//   the signature memory is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module signature_correlation_classifier_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic [scc_pkg::CLASS_W-1:0]         i_class_index,
    input  logic [scc_pkg::ELEM_W-1:0]          i_elem_index,
    input  logic signed [scc_pkg::VAL_W-1:0]    i_value_re,
    input  logic signed [scc_pkg::VAL_W-1:0]    i_value_im,
    input  logic                                i_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [scc_pkg::CLASS_W-1:0]         o_best_class
);

    localparam int NC = scc_pkg::NUM_CLASSES;

    logic                                   w_in_acc;
    logic                                   w_load_ok;
    logic                                   w_elem_ok;
    logic [scc_pkg::ADDR_W-1:0]             w_addr;
    logic                                   w_push;
    logic                                   w_pop;

    scc_pkg::t_sig_row                      r_sig_mem [scc_pkg::VEC_LEN];

    logic                                   r_s1_valid;
    logic                                   r_s1_hit;
    logic                                   r_s1_last;
    scc_pkg::t_cplx16                       r_s1_x;
    scc_pkg::t_sig_row                      r_s1_row;

    logic                                   r_s2_valid;
    logic                                   r_s2_hit;
    logic                                   r_s2_last;
    logic signed [scc_pkg::PROD_W-1:0]      r_s2_ap [NC];
    logic signed [scc_pkg::PROD_W-1:0]      r_s2_bq [NC];
    logic signed [scc_pkg::PROD_W-1:0]      r_s2_aq [NC];
    logic signed [scc_pkg::PROD_W-1:0]      r_s2_bp [NC];

    logic                                   r_s3_valid;
    logic                                   r_s3_last;
    logic signed [scc_pkg::TERM_W-1:0]      r_s3_tre [NC];
    logic signed [scc_pkg::TERM_W-1:0]      r_s3_tim [NC];

    scc_pkg::t_acc_pair [NC-1:0]            r_acc;
    scc_pkg::t_acc_pair [NC-1:0]            n_acc;
    scc_pkg::t_corr_req                     r_fin;
    scc_pkg::t_best_rsp                     w_best;

    logic [scc_pkg::CLASS_W-1:0]            r_fifo [scc_pkg::FIFO_DEPTH];
    logic [scc_pkg::FIFO_AW-1:0]            r_wr_ptr;
    logic [scc_pkg::FIFO_AW-1:0]            r_rd_ptr;
    logic [scc_pkg::FIFO_AW:0]              r_fifo_cnt;
    logic [scc_pkg::PEND_W-1:0]             r_pending;

    // input handshake and range checks
    assign o_in_stall = (r_pending == scc_pkg::PEND_W'(scc_pkg::FIFO_DEPTH));
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_elem_ok  = (32'(i_elem_index) < scc_pkg::VEC_LEN);
    assign w_load_ok  = w_elem_ok && (32'(i_class_index) < NC);
    assign w_addr     = scc_pkg::ADDR_W'(i_elem_index);

    // signature memory: one class word written, one row read
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_req_type == scc_pkg::REQ_LOAD && w_load_ok) begin
            r_sig_mem[w_addr][scc_pkg::CLS_IDX_W'(i_class_index)] <=
                {i_value_re, i_value_im};
        end
        if (w_in_acc && i_req_type == scc_pkg::REQ_FEATURE) begin
            r_s1_row <= r_sig_mem[w_addr];
        end
    end

    // stage 1 capture of the feature request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_acc && i_req_type == scc_pkg::REQ_FEATURE;
        end
        r_s1_hit  <= w_elem_ok;
        r_s1_last <= i_last;
        r_s1_x    <= {i_value_re, i_value_im};
    end

    // stage 2 products for all classes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_hit  <= r_s1_hit;
        r_s2_last <= r_s1_last;
        for (int c = 0; c < NC; c++) begin
            r_s2_ap[c] <= scc_pkg::PROD_W'(r_s1_row[c].re) * scc_pkg::PROD_W'(r_s1_x.re);
            r_s2_bq[c] <= scc_pkg::PROD_W'(r_s1_row[c].im) * scc_pkg::PROD_W'(r_s1_x.im);
            r_s2_aq[c] <= scc_pkg::PROD_W'(r_s1_row[c].re) * scc_pkg::PROD_W'(r_s1_x.im);
            r_s2_bp[c] <= scc_pkg::PROD_W'(r_s1_row[c].im) * scc_pkg::PROD_W'(r_s1_x.re);
        end
    end

    // stage 3 conjugate product terms, zero for an out-of-range element
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_last <= r_s2_last;
        for (int c = 0; c < NC; c++) begin
            r_s3_tre[c] <= r_s2_hit ?
                (scc_pkg::TERM_W'(r_s2_ap[c]) + scc_pkg::TERM_W'(r_s2_bq[c])) : '0;
            r_s3_tim[c] <= r_s2_hit ?
                (scc_pkg::TERM_W'(r_s2_aq[c]) - scc_pkg::TERM_W'(r_s2_bp[c])) : '0;
        end
    end

    // saturating accumulate
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n_acc[c].re = scc_pkg::sat_add(r_acc[c].re, r_s3_tre[c]);
            n_acc[c].im = scc_pkg::sat_add(r_acc[c].im, r_s3_tim[c]);
        end
    end

    // accumulators, handed off and cleared on the last element
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_fin.valid <= 1'b0;
        end else begin
            r_fin.valid <= r_s3_valid && r_s3_last;
            if (r_s3_valid) begin
                r_acc <= r_s3_last ? '0 : n_acc;
            end
        end
        r_fin.acc <= n_acc;
    end

    scc_best_select u_best_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_fin),
        .o_rsp   (w_best)
    );

    // result queue
    assign w_push = w_best.valid;
    assign w_pop  = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= scc_pkg::CLASS_W'(w_best.idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + scc_pkg::FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + scc_pkg::FIFO_AW'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + (scc_pkg::FIFO_AW+1)'(w_push)
                                     - (scc_pkg::FIFO_AW+1)'(w_pop);
        end
    end

    // outstanding results, from acceptance to delivery
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending
                + scc_pkg::PEND_W'(w_in_acc && i_req_type == scc_pkg::REQ_FEATURE && i_last)
                - scc_pkg::PEND_W'(w_pop);
        end
    end

    assign o_out_valid  = (r_fifo_cnt != '0);
    assign o_best_class = r_fifo[r_rd_ptr];

`ifndef SYNTH
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= scc_pkg::PEND_W'(scc_pkg::FIFO_DEPTH))
        else $error("outstanding result count exceeds queue depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_fifo_cnt < (scc_pkg::FIFO_AW+1)'(scc_pkg::FIFO_DEPTH)))
        else $error("result queue written while full");

    a_queue_le_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scc_pkg::PEND_W+1)'(r_fifo_cnt) <= (scc_pkg::PEND_W+1)'(r_pending))
        else $error("queue holds more results than were requested");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin.valid |-> (r_acc == '0))
        else $error("accumulators not cleared after a finished vector");
`endif

endmodule

[tb/tb_signature_correlation_classifier_unit.sv]
// ----------------------------------------------------------------------------
// tb_signature_correlation_classifier_unit
// Self-checking bench for the complex template classifier. Loads signature
// rows, streams feature vectors and keeps its own copy of the signature store
// and the per-class correlation sums, so it knows the winning class for every
// vector. Results are compared in order as they leave the block. Both sides
// idle at random, and one phase backs the output up until the input stalls.
// ----------------------------------------------------------------------------
module tb_signature_correlation_classifier_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 10;
    localparam int SETTLE_CYC  = LATENCY + 10;
    localparam int MAX_GAP     = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYC    = 200;
    localparam int FLOOD_REQS  = 40;
    localparam int REPORT_MAX  = 10;

    localparam logic signed [scc_pkg::VAL_W-1:0] ONE_Q14 = 16'sd16384;
    localparam logic signed [scc_pkg::VAL_W-1:0] VAL_MAX = 16'sh7FFF;
    localparam logic signed [scc_pkg::VAL_W-1:0] VAL_MIN = 16'sh8000;

    typedef struct packed {
        logic                             req_type;
        logic [scc_pkg::CLASS_W-1:0]      cls;
        logic [scc_pkg::ELEM_W-1:0]       elem;
        logic signed [scc_pkg::VAL_W-1:0] re;
        logic signed [scc_pkg::VAL_W-1:0] im;
        logic                             last;
    } t_req;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_stall;
    logic                             i_req_type;
    logic [scc_pkg::CLASS_W-1:0]      i_class_index;
    logic [scc_pkg::ELEM_W-1:0]       i_elem_index;
    logic signed [scc_pkg::VAL_W-1:0] i_value_re;
    logic signed [scc_pkg::VAL_W-1:0] i_value_im;
    logic                             i_last;
    logic                             o_out_valid;
    logic                             i_out_stall;
    logic [scc_pkg::CLASS_W-1:0]      o_best_class;

    // predictor state: signature store and correlation sums
    logic signed [scc_pkg::VAL_W-1:0] sig_re  [scc_pkg::VEC_LEN][scc_pkg::NUM_CLASSES];
    logic signed [scc_pkg::VAL_W-1:0] sig_im  [scc_pkg::VEC_LEN][scc_pkg::NUM_CLASSES];
    logic signed [scc_pkg::ACC_W-1:0] corr_re [scc_pkg::NUM_CLASSES];
    logic signed [scc_pkg::ACC_W-1:0] corr_im [scc_pkg::NUM_CLASSES];
    logic [scc_pkg::CLASS_W-1:0]      best_q  [$];

    // which signature words have been written, and rows safe to read
    bit                               word_loaded [scc_pkg::VEC_LEN][scc_pkg::NUM_CLASSES];
    bit                               row_ready   [scc_pkg::VEC_LEN];
    logic [scc_pkg::ELEM_W-1:0]       ready_elems [$];

    bit                               tx_idle;
    bit                               rx_idle;
    int                               rx_hold;
    int                               req_count;
    int                               mismatches;
    int                               quiet;
    logic [scc_pkg::CLASS_W-1:0]      want;

    signature_correlation_classifier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_class_index (i_class_index),
        .i_elem_index  (i_elem_index),
        .i_value_re    (i_value_re),
        .i_value_im    (i_value_im),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_best_class  (o_best_class)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // clamp a sum to the 48-bit accumulator range
    function automatic logic signed [scc_pkg::ACC_W-1:0] clamp_acc(input longint s);
        if (s > longint'(scc_pkg::ACC_MAX)) return scc_pkg::ACC_MAX;
        if (s < longint'(scc_pkg::ACC_MIN)) return scc_pkg::ACC_MIN;
        return s[scc_pkg::ACC_W-1:0];
    endfunction

    // exact squared magnitude of one correlation sum
    function automatic logic [scc_pkg::MAG_W-1:0] corr_energy(
        input logic signed [scc_pkg::ACC_W-1:0] x,
        input logic signed [scc_pkg::ACC_W-1:0] y
    );
        longint                    ax;
        longint                    ay;
        logic [scc_pkg::MAG_W-1:0] wx;
        logic [scc_pkg::MAG_W-1:0] wy;
        ax = longint'(x);
        ay = longint'(y);
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        wx = scc_pkg::MAG_W'(ax);
        wy = scc_pkg::MAG_W'(ay);
        return wx * wx + wy * wy;
    endfunction

    // update the predictor with one accepted request
    task automatic predict_request(input t_req r);
        longint                    p;
        longint                    q;
        longint                    a;
        longint                    b;
        logic [scc_pkg::MAG_W-1:0] energy;
        logic [scc_pkg::MAG_W-1:0] top;
        int                        winner;
        int                        c;
        if (r.req_type == scc_pkg::REQ_LOAD) begin
            sig_re[r.elem][r.cls] = r.re;
            sig_im[r.elem][r.cls] = r.im;
        end else begin
            p = longint'(r.re);
            q = longint'(r.im);
            // conj(signature) * feature into every class
            for (c = 0; c < scc_pkg::NUM_CLASSES; c++) begin
                a = longint'(sig_re[r.elem][c]);
                b = longint'(sig_im[r.elem][c]);
                corr_re[c] = clamp_acc(longint'(corr_re[c]) + a * p + b * q);
                corr_im[c] = clamp_acc(longint'(corr_im[c]) + a * q - b * p);
            end
            if (r.last) begin
                // strict compare keeps the lowest class on a tie
                winner = 0;
                top = corr_energy(corr_re[0], corr_im[0]);
                for (c = 1; c < scc_pkg::NUM_CLASSES; c++) begin
                    energy = corr_energy(corr_re[c], corr_im[c]);
                    if (energy > top) begin
                        top = energy;
                        winner = c;
                    end
                end
                best_q = {best_q, scc_pkg::CLASS_W'(winner)};
                for (c = 0; c < scc_pkg::NUM_CLASSES; c++) begin
                    corr_re[c] = '0;
                    corr_im[c] = '0;
                end
            end
        end
    endtask

    function automatic t_req make_req(input logic kind,
                                      input logic [scc_pkg::CLASS_W-1:0] cls,
                                      input logic [scc_pkg::ELEM_W-1:0] elem,
                                      input logic signed [scc_pkg::VAL_W-1:0] re,
                                      input logic signed [scc_pkg::VAL_W-1:0] im,
                                      input logic last);
        t_req r;
        r.req_type = kind;
        r.cls      = cls;
        r.elem     = elem;
        r.re       = re;
        r.im       = im;
        r.last     = last;
        return r;
    endfunction

    // random value with the extremes drawn often
    function automatic logic signed [scc_pkg::VAL_W-1:0] rand_val();
        case ($urandom_range(0, 7))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return '1;
            default: return scc_pkg::VAL_W'($urandom);
        endcase
    endfunction

    // features only read rows whose every class word has been written
    function automatic logic [scc_pkg::ELEM_W-1:0] pick_elem();
        return ready_elems[$urandom_range(0, ready_elems.size() - 1)];
    endfunction

    function automatic void note_load(input logic [scc_pkg::ELEM_W-1:0] elem,
                                      input logic [scc_pkg::CLASS_W-1:0] cls);
        bit full;
        word_loaded[elem][cls] = 1'b1;
        if (!row_ready[elem]) begin
            full = 1'b1;
            for (int c = 0; c < scc_pkg::NUM_CLASSES; c++) full &= word_loaded[elem][c];
            if (full) begin
                row_ready[elem] = 1'b1;
                ready_elems = {ready_elems, elem};
            end
        end
    endfunction

    // drive one request and wait until the block takes it
    task automatic send_req(input t_req r);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_req_type    <= r.req_type;
        i_class_index <= r.cls;
        i_elem_index  <= r.elem;
        i_value_re    <= r.re;
        i_value_im    <= r.im;
        i_last        <= r.last;
        do @(posedge i_clk); while (o_in_stall);
        req_count++;
        predict_request(r);
        if (r.req_type == scc_pkg::REQ_LOAD) note_load(r.elem, r.cls);
    endtask

    // drop valid and wait until every pending result has left the block
    task automatic settle_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (best_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // one signature row, words sometimes repeated so that classes tie
    task automatic load_row(input logic [scc_pkg::ELEM_W-1:0] elem);
        int                               rot;
        int                               k;
        logic signed [scc_pkg::VAL_W-1:0] re;
        logic signed [scc_pkg::VAL_W-1:0] im;
        rot = $urandom_range(0, scc_pkg::NUM_CLASSES - 1);
        re  = rand_val();
        im  = rand_val();
        for (k = 0; k < scc_pkg::NUM_CLASSES; k++) begin
            if ($urandom_range(0, 3) != 0) begin
                re = rand_val();
                im = rand_val();
            end
            send_req(make_req(scc_pkg::REQ_LOAD,
                              scc_pkg::CLASS_W'((k + rot) % scc_pkg::NUM_CLASSES), elem,
                              re, im, 1'($urandom)));
        end
    endtask

    task automatic send_stray_load();
        send_req(make_req(scc_pkg::REQ_LOAD, scc_pkg::CLASS_W'($urandom),
                          scc_pkg::ELEM_W'($urandom), rand_val(), rand_val(),
                          1'($urandom)));
    endtask

    // one feature vector, with an odd signature rewrite in the middle
    task automatic send_vector(input int len);
        int k;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0) send_stray_load();
            send_req(make_req(scc_pkg::REQ_FEATURE, scc_pkg::CLASS_W'($urandom), pick_elem(),
                              rand_val(), rand_val(), k == len - 1));
        end
    endtask

    // extremes, ties, all-zero sums and a read right after a write
    task automatic test_extremes_and_ties();
        // row 0: zero, unit real, unit imaginary, unit real again
        send_req(make_req(scc_pkg::REQ_LOAD, 2'd0, 8'h00, '0, '0, 1'b1));
        send_req(make_req(scc_pkg::REQ_LOAD, 2'd1, 8'h00, ONE_Q14, '0, 1'b0));
        send_req(make_req(scc_pkg::REQ_LOAD, 2'd2, 8'h00, '0, ONE_Q14, 1'b1));
        send_req(make_req(scc_pkg::REQ_LOAD, 2'd3, 8'h00, ONE_Q14, '0, 1'b0));
        send_req(make_req(scc_pkg::REQ_FEATURE, 2'd0, 8'h00, 16'sd100, '0, 1'b1));
        send_req(make_req(scc_pkg::REQ_FEATURE, 2'd3, 8'h00, '0, '0, 1'b1));
        // row 255 at the value extremes
        send_req(make_req(scc_pkg::REQ_LOAD, 2'd0, 8'hFF, VAL_MIN, VAL_MIN, 1'b0));
        send_req(make_req(scc_pkg::REQ_LOAD, 2'd1, 8'hFF, VAL_MAX, VAL_MAX, 1'b1));
        send_req(make_req(scc_pkg::REQ_LOAD, 2'd2, 8'hFF, VAL_MAX, VAL_MIN, 1'b0));
        send_req(make_req(scc_pkg::REQ_LOAD, 2'd3, 8'hFF, '0, '0, 1'b1));
        send_req(make_req(scc_pkg::REQ_FEATURE, 2'd3, 8'hFF, VAL_MIN, VAL_MAX, 1'b1));
        send_req(make_req(scc_pkg::REQ_FEATURE, 2'd2, 8'hFF, VAL_MAX, VAL_MIN, 1'b0));
        send_req(make_req(scc_pkg::REQ_FEATURE, 2'd1, 8'h00, VAL_MIN, VAL_MIN, 1'b1));
        send_req(make_req(scc_pkg::REQ_FEATURE, 2'd0, 8'hFF, VAL_MIN, VAL_MIN, 1'b0));
        send_req(make_req(scc_pkg::REQ_FEATURE, 2'd1, 8'hFF, VAL_MIN, VAL_MIN, 1'b0));
        send_req(make_req(scc_pkg::REQ_FEATURE, 2'd2, 8'hFF, VAL_MAX, VAL_MAX, 1'b1));
        // rewrite then read at once: minus one ties with class 1
        send_req(make_req(scc_pkg::REQ_LOAD, 2'd3, 8'h00, -ONE_Q14, '0, 1'b0));
        send_req(make_req(scc_pkg::REQ_FEATURE, 2'd0, 8'h00, -16'sd5, 16'sd7, 1'b1));
        settle_results();
    endtask

    // mixed loads and vectors, mostly short vectors with a few long ones
    task automatic test_random_stream(input int n_reqs);
        int stop;
        stop = req_count + n_reqs;
        while (req_count < stop) begin
            case ($urandom_range(0, 9))
                0, 1: load_row(scc_pkg::ELEM_W'($urandom));
                2: send_stray_load();
                default: send_vector(($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                                   : $urandom_range(1, 8));
            endcase
        end
        settle_results();
    endtask

    // receiver holds off while results pile up and the input stalls
    task automatic test_result_backpressure();
        int k;
        tx_idle = 1'b0;
        @(posedge i_clk);
        rx_hold = HOLD_CYC;
        for (k = 0; k < FLOOD_REQS; k++) begin
            send_req(make_req(scc_pkg::REQ_FEATURE, scc_pkg::CLASS_W'($urandom), pick_elem(),
                              rand_val(), rand_val(), 1'b1));
        end
        settle_results();
    endtask

    // receiver: random stall after each result, plus the long hold
    initial begin
        int wait_left;
        wait_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) wait_left = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_stall <= 1'b1;
            end else if (wait_left > 0) begin
                wait_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // compare every result with the oldest expected class
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (best_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: best_class=%0d, none expected", o_best_class);
            end else begin
                want = best_q.pop_front();
                if (o_best_class !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("best_class mismatch: expected %0d, got %0d", want,
                                 o_best_class);
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_req_type    = scc_pkg::REQ_LOAD;
        i_class_index = '0;
        i_elem_index  = '0;
        i_value_re    = '0;
        i_value_im    = '0;
        i_last        = 1'b0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        rx_hold       = 0;
        req_count     = 0;
        mismatches    = 0;
        for (int c = 0; c < scc_pkg::NUM_CLASSES; c++) begin
            corr_re[c] = '0;
            corr_im[c] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes_and_ties();
        test_random_stream(500);
        test_result_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random_stream(250);
        tx_idle = 1'b1;
        test_random_stream(150);
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        test_random_stream(200);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/scc_pkg.sv
rtl/scc_best_select.sv
rtl/signature_correlation_classifier_unit.sv
tb/tb_signature_correlation_classifier_unit.sv
